// File: rtl/bezier_path_follower_unit_macros.svh
// ----------------------------------------------------------------------------
// Bezier path follower assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef BEZIER_PATH_FOLLOWER_UNIT_MACROS_SVH
`define BEZIER_PATH_FOLLOWER_UNIT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define BPF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define BPF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/bpf_pkg.sv
// ----------------------------------------------------------------------------
// Bezier path follower package
// Widths, reset values, codes and shared types of the path follower.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bpf_pkg;

  // Payload formats
  localparam int COORD_W    = 32;             // signed Q16.16 coordinate
  localparam int PARAM_F    = 16;             // fraction bits of the curve parameter
  localparam int PARAM_W    = PARAM_F + 1;    // parameter incl. the value 1.0
  localparam int IDX_W      = 6;              // table slot field
  localparam int SEG_OUT_W  = 5;              // segment field on the result
  localparam int STEP_W     = 16;
  localparam int COUNT_W    = 7;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  localparam logic [PARAM_W-1:0] PARAM_ONE = PARAM_W'(1) << PARAM_F;

  // Segment geometry: four points per segment, neighbors share one point
  localparam int SEG_STRIDE = 3;
  localparam int SEG_SPAN   = 4;
  localparam int CNT_LIMIT  = (1 << COUNT_W) - 1;

  // Defaults
  localparam int POINTS_DEF      = 64;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam logic [STEP_W-1:0]  STEP_RESET  = STEP_W'(655);
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(4);

  // Arithmetic widths of the evaluator
  localparam int PT_W  = IDX_W + 3 * COORD_W;        // write request body
  localparam int SQ_W  = 2 * PARAM_F + 1;            // u*u, t*t
  localparam int TRI_W = PARAM_F + 2;                // 3*u, 3*t
  localparam int WGT_W = 3 * PARAM_F + 1;            // Bernstein weight, up to 1.0
  localparam int LO_W  = WGT_W / 2;                  // low half of a weight
  localparam int HI_W  = WGT_W - LO_W;               // high half of a weight
  localparam int PLO_W = LO_W + 1 + COORD_W;         // low partial product
  localparam int PHI_W = HI_W + 1 + COORD_W;         // high partial product
  localparam int ACC_W = WGT_W + COORD_W;            // weighted sum

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_TICK  = 1'b1
  } bpf_cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP  = 1'b0,
    CFG_COUNT = 1'b1
  } bpf_cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_CUBE,
    ST_MAC,
    ST_SUM,
    ST_OUT
  } bpf_state_e;

  // One queued request. A write carries {slot, x, y, z}; a tick carries
  // {segment, parameter} in the low bits of the body.
  typedef struct packed {
    bpf_cmd_e          cmd;
    logic [PT_W-1:0]   body;
  } bpf_job_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic [SEG_OUT_W-1:0]      seg;
    logic [PARAM_W-1:0]        param;
  } bpf_res_t;

endpackage

`default_nettype wire

// File: rtl/bpf_fifo.sv
// ----------------------------------------------------------------------------
// Bezier path follower request queue
// Small register queue between the front end and the evaluator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bpf_fifo #(
  parameter int DEPTH = bpf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  bpf_pkg::bpf_job_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output bpf_pkg::bpf_job_t data_o,
  output logic              empty_o
);
  import bpf_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bpf_job_t         store_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = store_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (do_push && !do_pop) cnt_q <= cnt_q + CNT_W'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) store_q[wr_ptr_q] <= data_i;
  end

endmodule

`default_nettype wire

// File: rtl/bpf_front.sv
// ----------------------------------------------------------------------------
// Bezier path follower front end
// Holds configuration, classifies input items, advances segment and parameter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "bezier_path_follower_unit_macros.svh"

module bpf_front #(
  parameter int POINTS = bpf_pkg::POINTS_DEF,
  parameter int SEG_W  = 5
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bpf_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [bpf_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              push_i,
  input  logic                              q_full_i,
  input  logic                              command_i,
  input  logic [bpf_pkg::IDX_W-1:0]         point_index_i,
  input  logic signed [bpf_pkg::COORD_W-1:0] point_x_i,
  input  logic signed [bpf_pkg::COORD_W-1:0] point_y_i,
  input  logic signed [bpf_pkg::COORD_W-1:0] point_z_i,
  output logic                              q_push_o,
  output bpf_pkg::bpf_job_t                 q_job_o
);
  import bpf_pkg::*;

  localparam int MAX_CNT = (POINTS < CNT_LIMIT) ? POINTS : CNT_LIMIT;
  localparam int CNT_W   = $clog2(MAX_CNT + 1);
  localparam int FIT_W   = SEG_W + 4;
  localparam int SUM_W   = PARAM_W + 1;

  logic [STEP_W-1:0]  step_q;
  logic [COUNT_W-1:0] count_q;
  logic [SEG_W-1:0]   seg_q, seg_d;
  logic [PARAM_W-1:0] param_q, param_d;

  logic               accept, is_tick;
  logic [CNT_W-1:0]   eff_cnt;
  logic [SEG_W-1:0]   seg_cur;
  logic [SEG_W:0]     seg_inc;
  logic [SUM_W-1:0]   sum;
  logic               wrap;

  // Segment s fits when its last point 3s+3 lies below the count in use.
  function automatic logic seg_fits(input logic [SEG_W:0] s, input logic [CNT_W-1:0] cnt);
    logic [FIT_W-1:0] last;
    last = FIT_W'(s) * FIT_W'(SEG_STRIDE) + FIT_W'(SEG_SPAN - 1);
    seg_fits = last < FIT_W'(cnt);
  endfunction

  assign accept   = push_i && !q_full_i;
  assign is_tick  = (bpf_cmd_e'(command_i) == CMD_TICK);
  assign q_push_o = accept;

  always_comb begin
    eff_cnt = (count_q > COUNT_W'(MAX_CNT)) ? CNT_W'(MAX_CNT) : CNT_W'(count_q);
    // Drop back to the first segment if the current one no longer fits
    seg_cur = seg_fits({1'b0, seg_q}, eff_cnt) ? seg_q : '0;
    sum     = SUM_W'(param_q) + SUM_W'(step_q);
    wrap    = sum > SUM_W'(PARAM_ONE);
    seg_inc = {1'b0, seg_cur} + (SEG_W + 1)'(1);
    if (wrap) begin
      param_d = '0;
      seg_d   = seg_fits(seg_inc, eff_cnt) ? SEG_W'(seg_inc) : '0;
    end else begin
      param_d = PARAM_W'(sum);
      seg_d   = seg_cur;
    end
  end

  always_comb begin
    q_job_o.cmd = bpf_cmd_e'(command_i);
    if (is_tick) begin
      q_job_o.body = PT_W'({seg_d, param_d});
    end else begin
      q_job_o.body = {point_index_i, point_x_i, point_y_i, point_z_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= STEP_RESET;
      count_q <= COUNT_RESET;
    end else if (cfg_we_i) begin
      case (bpf_cfg_e'(cfg_index_i))
        CFG_STEP:  step_q  <= cfg_data_i[STEP_W-1:0];
        CFG_COUNT: count_q <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q   <= '0;
      param_q <= '0;
    end else if (accept && is_tick) begin
      seg_q   <= seg_d;
      param_q <= param_d;
    end
  end

  `BPF_ASSERT_IMP(a_param_range, 1'b1, param_q <= PARAM_ONE, "parameter above 1.0")
  `BPF_ASSERT_NXT(a_param_wrap, accept && is_tick && wrap, param_q == '0, "no reset on wrap")
  `BPF_ASSERT_NXT(a_write_hold, accept && !is_tick, param_q == $past(param_q) && seg_q == $past(seg_q), "point write moved the path state")

endmodule

`default_nettype wire

// File: rtl/bpf_back.sv
// ----------------------------------------------------------------------------
// Bezier path follower evaluator
// Point table, Bernstein weights and three multiply-accumulate lanes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "bezier_path_follower_unit_macros.svh"

module bpf_back #(
  parameter int POINTS = bpf_pkg::POINTS_DEF,
  parameter int SEG_W  = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  bpf_pkg::bpf_job_t q_job_i,
  output logic              q_pop_o,
  input  logic              res_pop_i,
  output logic              res_empty_o,
  output bpf_pkg::bpf_res_t res_o
);
  import bpf_pkg::*;

  localparam int AW    = $clog2(POINTS);
  localparam int ROW_W = 3 * COORD_W;
  localparam int LANES = 3;
  localparam logic [1:0] K_LAST = 2'd3;

  bpf_state_e state_q, state_d;

  // Request decode
  logic [PARAM_W-1:0] job_t;
  logic [SEG_W-1:0]   job_seg;
  logic [IDX_W-1:0]   wr_idx;
  logic [ROW_W-1:0]   wr_data;
  logic               is_tick;

  // Control
  logic               mem_we, rd_en, load_out;
  logic [1:0]         k_q, k_d, rd_k;
  logic [AW-1:0]      rd_addr, base_q;

  // Datapath
  logic [ROW_W-1:0]   mem [POINTS];
  logic [ROW_W-1:0]   rd_q;
  logic [SEG_W-1:0]   seg_q;
  logic [PARAM_W-1:0] t_q, u_q;
  logic [SQ_W-1:0]    uu_q, tt_q;
  logic [TRI_W-1:0]   u3_q, t3_q;
  logic [WGT_W-1:0]   w_q [4];
  logic [SQ_W+TRI_W-1:0] cube_full [4];
  logic [WGT_W-1:0]   w_sel;

  logic signed [PLO_W-1:0] plo_d [LANES];
  logic signed [PLO_W-1:0] plo_q [LANES];
  logic signed [PHI_W-1:0] phi_d [LANES];
  logic signed [PHI_W-1:0] phi_q [LANES];
  logic signed [ACC_W-1:0] acc_q [LANES];
  logic signed [ACC_W-1:0] acc_d [LANES];
  logic                    prod_v_q;

  logic     out_valid_q;
  bpf_res_t out_q;

  assign is_tick = (q_job_i.cmd == CMD_TICK);
  assign job_t   = q_job_i.body[PARAM_W-1:0];
  assign job_seg = q_job_i.body[PARAM_W +: SEG_W];
  assign wr_idx  = q_job_i.body[PT_W-1 -: IDX_W];
  assign wr_data = q_job_i.body[ROW_W-1:0];
  assign rd_addr = base_q + AW'(rd_k);

  // Sequencer
  always_comb begin
    state_d  = state_q;
    q_pop_o  = 1'b0;
    mem_we   = 1'b0;
    rd_en    = 1'b0;
    rd_k     = k_q;
    k_d      = k_q;
    load_out = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          if (is_tick) begin
            state_d = ST_SQUARE;
          end else begin
            mem_we = (32'(wr_idx) < POINTS);
          end
        end
      end
      ST_SQUARE: begin
        state_d = ST_CUBE;
      end
      ST_CUBE: begin
        rd_en   = 1'b1;
        rd_k    = '0;
        k_d     = '0;
        state_d = ST_MAC;
      end
      ST_MAC: begin
        rd_en = (k_q != K_LAST);
        rd_k  = k_q + 2'd1;
        k_d   = k_q + 2'd1;
        if (k_q == K_LAST) state_d = ST_SUM;
      end
      ST_SUM: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || res_pop_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      prod_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      k_q      <= k_d;
      prod_v_q <= (state_q == ST_MAC);
      if (load_out)       out_valid_q <= 1'b1;
      else if (res_pop_i) out_valid_q <= 1'b0;
    end
  end

  // Point table: one write or one row read per cycle, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[AW'(wr_idx)] <= wr_data;
    if (rd_en)  rd_q <= mem[rd_addr];
  end

  // Weight products: u^3, 3u^2t, 3ut^2, t^3
  always_comb begin
    cube_full[0] = uu_q * u_q;
    cube_full[1] = uu_q * t3_q;
    cube_full[2] = tt_q * u3_q;
    cube_full[3] = tt_q * t_q;
  end

  // Split the selected weight into halves, one partial product each
  always_comb begin
    w_sel = w_q[k_q];
    for (int c = 0; c < LANES; c++) begin
      plo_d[c] = $signed({1'b0, w_sel[LO_W-1:0]}) *
                 $signed(rd_q[(LANES-1-c)*COORD_W +: COORD_W]);
      phi_d[c] = $signed({1'b0, w_sel[WGT_W-1:LO_W]}) *
                 $signed(rd_q[(LANES-1-c)*COORD_W +: COORD_W]);
      acc_d[c] = acc_q[c] + (ACC_W'(phi_q[c]) <<< LO_W) + ACC_W'(plo_q[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && q_pop_o && is_tick) begin
      seg_q  <= job_seg;
      t_q    <= job_t;
      u_q    <= PARAM_ONE - job_t;
      base_q <= AW'(job_seg) * AW'(SEG_STRIDE);
    end
    if (state_q == ST_SQUARE) begin
      uu_q <= SQ_W'(u_q * u_q);
      tt_q <= SQ_W'(t_q * t_q);
      u3_q <= TRI_W'(u_q) * TRI_W'(SEG_STRIDE);
      t3_q <= TRI_W'(t_q) * TRI_W'(SEG_STRIDE);
    end
    if (state_q == ST_CUBE) begin
      for (int i = 0; i < 4; i++) begin
        w_q[i] <= cube_full[i][WGT_W-1:0];
      end
      for (int c = 0; c < LANES; c++) begin
        acc_q[c] <= '0;
      end
    end else if (prod_v_q) begin
      for (int c = 0; c < LANES; c++) begin
        acc_q[c] <= acc_d[c];
      end
    end
    if (state_q == ST_MAC) begin
      for (int c = 0; c < LANES; c++) begin
        plo_q[c] <= plo_d[c];
        phi_q[c] <= phi_d[c];
      end
    end
    if (load_out) begin
      out_q.pos_x <= acc_q[0][3*PARAM_F +: COORD_W];
      out_q.pos_y <= acc_q[1][3*PARAM_F +: COORD_W];
      out_q.pos_z <= acc_q[2][3*PARAM_F +: COORD_W];
      out_q.seg   <= SEG_OUT_W'(seg_q);
      out_q.param <= t_q;
    end
  end

  assign res_empty_o = !out_valid_q;
  assign res_o       = out_q;

  `BPF_ASSERT_IMP(a_pop_idle, q_pop_o, state_q == ST_IDLE && !q_empty_i, "request taken while busy")
  `BPF_ASSERT_IMP(a_prod_seq, prod_v_q, state_q == ST_MAC || state_q == ST_SUM, "stray partial product")
  `BPF_ASSERT_IMP(a_rd_range, rd_en, 32'(rd_addr) < POINTS, "table read beyond last slot")

endmodule

`default_nettype wire

// File: rtl/bezier_path_follower_unit.sv
// ----------------------------------------------------------------------------
// Bezier path follower unit
// A tick passes the queue, then the square, cube, MAC, sum and output states;
// a point write yields no result. The evaluator takes no new request during a
// tick's four-point MAC pass on the single table read port or an output stall.
// Reset: path state and queues clear, registers reload; table undefined.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bezier_path_follower_unit #(
  parameter int POINTS      = bpf_pkg::POINTS_DEF,
  parameter int QUEUE_DEPTH = bpf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write port
  input  logic                               cfg_we_i,
  input  logic [bpf_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bpf_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // Request side
  input  logic                               push,
  output logic                               full,
  input  logic                               command_i,
  input  logic [bpf_pkg::IDX_W-1:0]          point_index_i,
  input  logic signed [bpf_pkg::COORD_W-1:0] point_x_i,
  input  logic signed [bpf_pkg::COORD_W-1:0] point_y_i,
  input  logic signed [bpf_pkg::COORD_W-1:0] point_z_i,
  // Result side
  output logic                               empty,
  input  logic                               pop,
  output logic signed [bpf_pkg::COORD_W-1:0] pos_x_o,
  output logic signed [bpf_pkg::COORD_W-1:0] pos_y_o,
  output logic signed [bpf_pkg::COORD_W-1:0] pos_z_o,
  output logic [bpf_pkg::SEG_OUT_W-1:0]      segment_now_o,
  output logic [bpf_pkg::PARAM_W-1:0]        param_now_o
);
  import bpf_pkg::*;

  // The segment counter only has to reach the last segment that fits in the
  // table, and the point count register caps the count in use anyway.
  localparam int MAX_CNT = (POINTS < CNT_LIMIT) ? POINTS : CNT_LIMIT;
  localparam int MAX_SEG = (MAX_CNT - SEG_SPAN) / SEG_STRIDE;
  localparam int SEG_W   = (MAX_SEG > 1) ? $clog2(MAX_SEG + 1) : 1;

  logic     q_push, q_full, q_pop, q_empty;
  bpf_job_t q_job_in, q_job_out;
  bpf_res_t res;

  // Front end: config registers, classify each request and advance the
  // segment/parameter state at accept time, so every tick request carries
  // the exact segment and parameter it must be evaluated at.
  bpf_front #(
    .POINTS (POINTS),
    .SEG_W  (SEG_W)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .push_i        (push),
    .q_full_i      (q_full),
    .command_i     (command_i),
    .point_index_i (point_index_i),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .point_z_i     (point_z_i),
    .q_push_o      (q_push),
    .q_job_o       (q_job_in)
  );

  // Request queue: point writes and ticks stay in order, so a write never
  // lands in the table ahead of an earlier tick that still reads it.
  bpf_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_job_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_job_out),
    .empty_o (q_empty)
  );

  // Evaluator: stores points, forms the four Bernstein weights exactly and
  // sums weight * point over four table reads in three coordinate lanes.
  // The result register decouples it from the consumer.
  bpf_back #(
    .POINTS (POINTS),
    .SEG_W  (SEG_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_job_i     (q_job_out),
    .q_pop_o     (q_pop),
    .res_pop_i   (pop),
    .res_empty_o (empty),
    .res_o       (res)
  );

  // Accept new requests while the queue has room, even with a result held
  assign full          = q_full;
  assign pos_x_o       = res.pos_x;
  assign pos_y_o       = res.pos_y;
  assign pos_z_o       = res.pos_z;
  assign segment_now_o = res.seg;
  assign param_now_o   = res.param;

endmodule

`default_nettype wire

// File: bench/bezier_position_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bezier position checker
// Watches the request, result and register ports of the path follower, keeps
// its own copy of the point table, segment and parameter, works out the exact
// curve position for every accepted tick and compares it field by field with
// the results in order.
// ----------------------------------------------------------------------------
module bezier_position_checker
  import bpf_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                      push,
  input  logic                      full,
  input  logic                      command_i,
  input  logic [IDX_W-1:0]          point_index_i,
  input  logic signed [COORD_W-1:0] point_x_i,
  input  logic signed [COORD_W-1:0] point_y_i,
  input  logic signed [COORD_W-1:0] point_z_i,
  input  logic                      empty,
  input  logic                      pop,
  input  logic signed [COORD_W-1:0] pos_x_o,
  input  logic signed [COORD_W-1:0] pos_y_o,
  input  logic signed [COORD_W-1:0] pos_z_o,
  input  logic [SEG_OUT_W-1:0]      segment_now_o,
  input  logic [PARAM_W-1:0]        param_now_o,
  output int                        mismatch_count_o,
  output int                        positions_due_o
);

  localparam int TABLE_DEPTH = POINTS_DEF;
  localparam int FIX_SHIFT   = 3 * PARAM_F;

  logic signed [COORD_W-1:0] point_tab [TABLE_DEPTH][3];
  logic [STEP_W-1:0]         step_q;
  logic [COUNT_W-1:0]        count_q;
  int unsigned               seg_q;
  int unsigned               param_q;
  bpf_res_t                  positions_due [$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: position check %s: got %0h, predicted %0h", $time, what, got, want);
    mismatch_count_o++;
  endtask

  // Move the parameter and segment by one tick, then evaluate the cubic
  // Bernstein sum exactly and floor it back to Q16.16.
  function automatic bpf_res_t advance_path();
    int unsigned               lim;
    longint unsigned           t, u;
    longint unsigned           w [4];
    logic signed [127:0]       acc, wt, cw;
    logic signed [COORD_W-1:0] coord [3];
    bpf_res_t                  r;
    int                        a, k;
    lim = (count_q > TABLE_DEPTH) ? TABLE_DEPTH : count_q;
    if (seg_q * SEG_STRIDE + 3 >= lim) seg_q = 0;
    param_q += step_q;
    if (param_q > PARAM_ONE) begin
      param_q = 0;
      seg_q++;
      if (seg_q * SEG_STRIDE + 3 >= lim) seg_q = 0;
    end
    t = param_q;
    u = PARAM_ONE - param_q;
    w[0] = u * u * u;
    w[1] = 3 * u * u * t;
    w[2] = 3 * u * t * t;
    w[3] = t * t * t;
    for (a = 0; a < 3; a++) begin
      acc = '0;
      for (k = 0; k < SEG_SPAN; k++) begin
        wt  = {64'd0, w[k]};
        cw  = point_tab[seg_q * SEG_STRIDE + k][a];
        acc = acc + wt * cw;
      end
      coord[a] = acc[FIX_SHIFT +: COORD_W];
    end
    r.pos_x = coord[0];
    r.pos_y = coord[1];
    r.pos_z = coord[2];
    r.seg   = seg_q[SEG_OUT_W-1:0];
    r.param = param_q[PARAM_W-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bpf_res_t seen, want;
    if (!rst_ni) begin
      step_q  = STEP_RESET;
      count_q = COUNT_RESET;
      seg_q   = 0;
      param_q = 0;
      positions_due.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_STEP:  step_q  = cfg_data_i[STEP_W-1:0];
          CFG_COUNT: count_q = cfg_data_i[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (push && !full) begin
        if (command_i == CMD_TICK) begin
          positions_due = {positions_due, advance_path()};
        end else begin
          point_tab[point_index_i][0] = point_x_i;
          point_tab[point_index_i][1] = point_y_i;
          point_tab[point_index_i][2] = point_z_i;
        end
      end
      if (!empty && pop) begin
        seen = '{pos_x_o, pos_y_o, pos_z_o, segment_now_o, param_now_o};
        if (positions_due.size() == 0) begin
          report_mismatch("result with nothing due, pos_x", seen.pos_x, '0);
        end else begin
          want = positions_due.pop_front();
          if (seen.pos_x !== want.pos_x) report_mismatch("pos_x", seen.pos_x, want.pos_x);
          if (seen.pos_y !== want.pos_y) report_mismatch("pos_y", seen.pos_y, want.pos_y);
          if (seen.pos_z !== want.pos_z) report_mismatch("pos_z", seen.pos_z, want.pos_z);
          if (seen.seg !== want.seg) report_mismatch("segment_now", seen.seg, want.seg);
          if (seen.param !== want.param) report_mismatch("param_now", seen.param, want.param);
        end
      end
    end
    positions_due_o = positions_due.size();
  end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bezier path follower testbench
// Loads control points, steps the curve parameter through many register
// settings and checks every position against an exact fixed-point model in
// the position checker. The sender runs in bursts, the receiver stalls on
// its own pattern, and once it holds off long enough to back up the block.
// ----------------------------------------------------------------------------
module tb_top;
  import bpf_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 20;      // well past the tick latency
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 190;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_PHASE    = 2;

  logic                      clk_i         = 1'b0;
  logic                      rst_ni        = 1'b0;
  logic                      cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index_i   = CFG_STEP;
  logic [CFG_DATA_W-1:0]     cfg_data_i    = '0;
  logic                      push          = 1'b0;
  logic                      full;
  logic                      command_i     = CMD_WRITE;
  logic [IDX_W-1:0]          point_index_i = '0;
  logic signed [COORD_W-1:0] point_x_i     = '0;
  logic signed [COORD_W-1:0] point_y_i     = '0;
  logic signed [COORD_W-1:0] point_z_i     = '0;
  logic                      empty;
  logic                      pop           = 1'b0;
  logic signed [COORD_W-1:0] pos_x_o;
  logic signed [COORD_W-1:0] pos_y_o;
  logic signed [COORD_W-1:0] pos_z_o;
  logic [SEG_OUT_W-1:0]      segment_now_o;
  logic [PARAM_W-1:0]        param_now_o;

  int mismatches;
  int positions_due;
  int burst_left = 0;
  bit hold_req   = 1'b0;

  always #2 clk_i = ~clk_i;

  bezier_path_follower_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .push         (push),
    .full         (full),
    .command_i    (command_i),
    .point_index_i(point_index_i),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .point_z_i    (point_z_i),
    .empty        (empty),
    .pop          (pop),
    .pos_x_o      (pos_x_o),
    .pos_y_o      (pos_y_o),
    .pos_z_o      (pos_z_o),
    .segment_now_o(segment_now_o),
    .param_now_o  (param_now_o)
  );

  bezier_position_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .push            (push),
    .full            (full),
    .command_i       (command_i),
    .point_index_i   (point_index_i),
    .point_x_i       (point_x_i),
    .point_y_i       (point_y_i),
    .point_z_i       (point_z_i),
    .empty           (empty),
    .pop             (pop),
    .pos_x_o         (pos_x_o),
    .pos_y_o         (pos_y_o),
    .pos_z_o         (pos_z_o),
    .segment_now_o   (segment_now_o),
    .param_now_o     (param_now_o),
    .mismatch_count_o(mismatches),
    .positions_due_o (positions_due)
  );

  // Offer one request. Open a new burst after a random gap when the current
  // one is used up; a zero gap lets bursts run together with no idling.
  // Keep push high on return so back-to-back requests need no second drive.
  task automatic offer(input logic cmd, input logic [IDX_W-1:0] slot,
                       input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                       input logic [COORD_W-1:0] z);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk_i);
        push <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk_i);
    push          <= 1'b1;
    command_i     <= cmd;
    point_index_i <= slot;
    point_x_i     <= x;
    point_y_i     <= y;
    point_z_i     <= z;
    // Hold the request until the block takes it.
    do @(posedge clk_i); while (full);
  endtask

  task automatic write_point(input logic [IDX_W-1:0] slot, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z);
    offer(CMD_WRITE, slot, x, y, z);
  endtask

  // Tick payload is don't-care; drive noise on it.
  task automatic tick();
    offer(CMD_TICK, IDX_W'($urandom), $urandom, $urandom, $urandom);
  endtask

  // Drop push, wait until every predicted position has come back, then let
  // a trailing point write finish inside the block.
  task automatic drain();
    @(negedge clk_i);
    push <= 1'b0;
    burst_left = 0;
    while (positions_due != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Write both registers; only call with the block drained. Noise on the
  // unused high bits of the count write must be ignored.
  task automatic set_path(input logic [STEP_W-1:0] step, input logic [COUNT_W-1:0] count);
    logic [CFG_DATA_W-1:0] data;
    data = $urandom;
    data[COUNT_W-1:0] = count;
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_STEP;
    cfg_data_i  <= step;
    @(negedge clk_i);
    cfg_index_i <= CFG_COUNT;
    cfg_data_i  <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Bias coordinates toward the corners of the signed range.
  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Exact powers of two land on t = 1.0; large steps move segments often.
  function automatic logic [STEP_W-1:0] pick_step();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3:       return 16'h4000;
      4:       return STEP_W'($urandom_range(2048, 65535));
      default: return STEP_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [COUNT_W-1:0] pick_count();
    case ($urandom_range(0, 5))
      0:       return 7'd64;
      1:       return 7'd127;
      2:       return 7'd4;
      3:       return COUNT_W'($urandom_range(0, 3));
      4:       return 7'd7;
      default: return COUNT_W'($urandom_range(4, 127));
    endcase
  endfunction

  // Receiver: pop on a pattern that is redrawn after a random run, and
  // once, on request from the stimulus, hold off long enough to fill the
  // block and push back on the sender.
  initial begin : receiver
    int pattern;
    int pattern_left;
    bit held;
    pattern      = 0;
    pattern_left = 0;
    held         = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !held) begin
        held = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else begin
        if (pattern_left == 0) begin
          pattern      = $urandom_range(0, 3);
          pattern_left = $urandom_range(16, 96);
        end
        pattern_left--;
        case (pattern)
          0:       pop <= 1'b1;
          1:       pop <= $urandom_range(0, 1);
          2:       pop <= ($urandom_range(0, 7) == 0);
          default: pop <= ~pop;
        endcase
      end
    end
  end

  // End the run if it hangs.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin : stimulus
    int slot;
    int phase;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. Load the first segment with range extremes and step
    // it at the reset register values.
    write_point(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
    write_point(1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    write_point(2, 32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF);
    write_point(3, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000);
    repeat (3) tick();
    drain();

    // Largest step: the first and third ticks pass 1.0, reset t and wrap
    // back to segment 0 since only one segment fits.
    set_path(16'hFFFF, 7'd4);
    repeat (3) tick();
    drain();

    // Half steps: land exactly on t = 1.0, then pass it.
    set_path(16'h8000, 7'd4);
    repeat (3) tick();
    drain();

    // Too few points for a segment: segment 0 stays in use. A point write
    // between ticks must not move the parameter.
    set_path(16'h0000, 7'd2);
    tick();
    write_point(0, 32'h0001_0000, 32'hFFFF_0000, 32'h8000_0001);
    tick();
    drain();
    set_path(16'h0000, 7'd0);
    tick();
    drain();

    // Fill the whole table so every segment reachable later reads written
    // points only.
    for (slot = 0; slot < POINTS_DEF; slot++) begin
      write_point(IDX_W'(slot), pick_coord(), pick_coord(), pick_coord());
    end
    drain();

    // Random phases, each under its own register setting; drain in between.
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       set_path(16'h4000, 7'd127);   // count beyond the table
        1:       set_path(16'hFFFF, 7'd64);
        default: set_path(pick_step(), pick_count());
      endcase
      if (phase == HOLD_PHASE) begin
        @(posedge clk_i);
        hold_req = 1'b1;
      end
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 4) == 0) begin
          write_point(IDX_W'($urandom), pick_coord(), pick_coord(), pick_coord());
        end else begin
          tick();
        end
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
